FILE: rtl/core/dgrt_pkg.sv
// Package for the DDA grid ray traversal block: map and fixed-point widths,
// status and mode codes, and the packed payload and map port structs.
// No dependencies; every other file in rtl/core uses it.
package dgrt_pkg;

  // Map geometry and fixed-point format
  localparam int unsigned MAP_W     = 64;
  localparam int unsigned MAP_H     = 64;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COORD_W   = 6;
  localparam int unsigned CELL_AW   = 2 * COORD_W;
  localparam int unsigned MAP_CELLS = MAP_W * MAP_H;
  localparam int unsigned POS_W     = COORD_W + FRAC_BITS;
  localparam int unsigned DELTA_W   = 32;
  localparam int unsigned SIDE_W    = 40;
  localparam int unsigned STEP_W    = 12;
  localparam int unsigned SPAN_W    = FRAC_BITS + 1;
  localparam int unsigned PROD_W    = SPAN_W + DELTA_W;

  localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = STEP_W'(128);

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_WALL  = 2'd0;
  localparam logic [1:0] STATUS_LEFT  = 2'd1;
  localparam logic [1:0] STATUS_LIMIT = 2'd2;

  // Hit side codes
  localparam logic SIDE_X = 1'b0;
  localparam logic SIDE_Y = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic                 cell_wall;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic                 dir_x_negative;
    logic                 dir_y_negative;
    logic [DELTA_W-1:0]   delta_x;
    logic [DELTA_W-1:0]   delta_y;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0]   hit_x;
    logic [COORD_W-1:0]   hit_y;
    logic                 hit_side;
    logic [SIDE_W-1:0]    final_side_x;
    logic [SIDE_W-1:0]    final_side_y;
    logic [STEP_W-1:0]    steps_taken;
    logic [1:0]           status;
  } out_t;

  // Map write request
  typedef struct packed {
    logic                 en;
    logic [CELL_AW-1:0]   addr;
    logic                 wall;
  } map_wr_t;

endpackage

FILE: rtl/core/dgrt_map.sv
// Wall map storage for the DDA traversal: one-bit memory, one write port,
// one registered read port, and a clearing sweep after reset.
// Depends on dgrt_pkg.
module dgrt_map (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dgrt_pkg::map_wr_t            wr_i,
  input  logic [dgrt_pkg::CELL_AW-1:0] rd_addr_i,
  output logic                         rd_wall_o,
  output logic                         ready_o
);

  logic                        mem_q [dgrt_pkg::MAP_CELLS];
  logic [dgrt_pkg::CELL_AW:0]  clr_cnt_q;
  logic [dgrt_pkg::CELL_AW:0]  clr_cnt_d;
  logic                        rd_wall_q;

  // Sweep ends once the counter reaches the cell count (top bit set)
  assign ready_o   = clr_cnt_q[dgrt_pkg::CELL_AW];
  assign clr_cnt_d = ready_o ? clr_cnt_q : clr_cnt_q + (dgrt_pkg::CELL_AW + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Clear one cell per cycle, then take cell writes
  always_ff @(posedge clk_i) begin
    if (!ready_o) begin
      mem_q[clr_cnt_q[dgrt_pkg::CELL_AW-1:0]] <= 1'b0;
    end else if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.wall;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rd_wall_q <= mem_q[rd_addr_i];
  end

  assign rd_wall_o = rd_wall_q;

endmodule

FILE: rtl/core/dda_grid_ray_traversal.sv
// DDA grid ray traversal over a 64 x 64 one-bit wall map. After reset the map
// is swept clear, during which in_stall_o stays high; the step_limit register
// is taken on the config channel at any time, but write it only while no ray
// is in flight. A map write item goes to the memory on its transfer and gives
// no result. A cast item passes from its transfer to the output register
// through S_MULX and S_MULY on the shared multiplier for the initial side
// distances, S_INIT to settle, then per grid step S_STEP on the shared compare
// and saturating adder and S_LOOK for the registered map read, skipped when
// the ray leaves the map since that step needs no map read, and S_DONE to hand
// the result over. The block takes one item at a time; the output register
// lets a new item in while the last result waits to be transferred.
// Depends on dgrt_pkg and dgrt_map.
module dda_grid_ray_traversal (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  dgrt_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output dgrt_pkg::out_t              out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dgrt_pkg::STEP_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_INIT,
    S_STEP,
    S_LOOK,
    S_DONE
  } state_e;

  localparam logic [dgrt_pkg::COORD_W-1:0] X_LAST = dgrt_pkg::COORD_W'(dgrt_pkg::MAP_W - 1);
  localparam logic [dgrt_pkg::COORD_W-1:0] Y_LAST = dgrt_pkg::COORD_W'(dgrt_pkg::MAP_H - 1);
  localparam logic [dgrt_pkg::SPAN_W-1:0]  ONE    = dgrt_pkg::SPAN_W'(1) << dgrt_pkg::FRAC_BITS;

  state_e                             state_q, state_d;
  logic [dgrt_pkg::COORD_W-1:0]       mx_q, mx_d, my_q, my_d;
  logic [dgrt_pkg::FRAC_BITS-1:0]     fx_q, fx_d, fy_q, fy_d;
  logic                               nx_q, nx_d, ny_q, ny_d;
  logic [dgrt_pkg::DELTA_W-1:0]       dx_q, dx_d, dy_q, dy_d;
  logic [dgrt_pkg::PROD_W-1:0]        prod_q, prod_d;
  logic [dgrt_pkg::SIDE_W-1:0]        sx_q, sx_d, sy_q, sy_d;
  logic [dgrt_pkg::STEP_W-1:0]        steps_q, steps_d;
  logic                               side_q, side_d;
  logic [1:0]                         status_q, status_d;
  logic [dgrt_pkg::STEP_W-1:0]        limit_q;
  dgrt_pkg::out_t                     out_q;
  logic                               out_valid_q;

  logic                               in_xfer;
  logic                               out_load;
  logic                               map_ready;
  logic                               map_wall;
  dgrt_pkg::map_wr_t                  map_wr;
  logic [dgrt_pkg::SPAN_W-1:0]        span_x, span_y, mul_a;
  logic [dgrt_pkg::DELTA_W-1:0]       mul_b;
  logic [dgrt_pkg::PROD_W-1:0]        prod;
  logic                               take_x;
  logic [dgrt_pkg::SIDE_W-1:0]        add_a;
  logic [dgrt_pkg::DELTA_W-1:0]       add_b;
  logic [dgrt_pkg::SIDE_W:0]          sum;
  logic [dgrt_pkg::SIDE_W-1:0]        sum_sat;
  logic                               leave;

  assign in_stall_o  = !(state_q == S_IDLE && map_ready);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Map cell writes go straight to the memory on transfer
  assign map_wr.en   = in_xfer && (in_data_i.mode == dgrt_pkg::MODE_WRITE);
  assign map_wr.addr = {in_data_i.cell_y, in_data_i.cell_x};
  assign map_wr.wall = in_data_i.cell_wall;

  dgrt_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (map_wr),
    .rd_addr_i ({my_d, mx_d}),
    .rd_wall_o (map_wall),
    .ready_o   (map_ready)
  );

  // Shared multiplier: span times delta, x first then y
  assign span_x = nx_q ? {1'b0, fx_q} : ONE - {1'b0, fx_q};
  assign span_y = ny_q ? {1'b0, fy_q} : ONE - {1'b0, fy_q};
  assign mul_a  = (state_q == S_MULX) ? span_x : span_y;
  assign mul_b  = (state_q == S_MULX) ? dx_q : dy_q;
  assign prod   = dgrt_pkg::PROD_W'(mul_a) * dgrt_pkg::PROD_W'(mul_b);

  // Shared compare and saturating adder; y wins ties
  assign take_x  = sx_q < sy_q;
  assign add_a   = take_x ? sx_q : sy_q;
  assign add_b   = take_x ? dx_q : dy_q;
  assign sum     = {1'b0, add_a} + (dgrt_pkg::SIDE_W + 1)'(add_b);
  assign sum_sat = sum[dgrt_pkg::SIDE_W] ? '1 : sum[dgrt_pkg::SIDE_W-1:0];

  // Stepping off the map edge on the chosen axis
  always_comb begin
    if (take_x) begin
      leave = nx_q ? (mx_q == '0) : (mx_q == X_LAST);
    end else begin
      leave = ny_q ? (my_q == '0) : (my_q == Y_LAST);
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    mx_d     = mx_q;
    my_d     = my_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    nx_d     = nx_q;
    ny_d     = ny_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    prod_d   = prod_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    steps_d  = steps_q;
    side_d   = side_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        // The start cell is the 6-bit integer part, so it always lies inside
        // the map
        if (in_xfer && in_data_i.mode == dgrt_pkg::MODE_CAST) begin
          mx_d    = in_data_i.pos_x[dgrt_pkg::POS_W-1:dgrt_pkg::FRAC_BITS];
          my_d    = in_data_i.pos_y[dgrt_pkg::POS_W-1:dgrt_pkg::FRAC_BITS];
          fx_d    = in_data_i.pos_x[dgrt_pkg::FRAC_BITS-1:0];
          fy_d    = in_data_i.pos_y[dgrt_pkg::FRAC_BITS-1:0];
          nx_d    = in_data_i.dir_x_negative;
          ny_d    = in_data_i.dir_y_negative;
          dx_d    = in_data_i.delta_x;
          dy_d    = in_data_i.delta_y;
          state_d = S_MULX;
        end
      end
      S_MULX: begin
        prod_d  = prod;
        state_d = S_MULY;
      end
      S_MULY: begin
        sx_d    = dgrt_pkg::SIDE_W'(prod_q >> dgrt_pkg::FRAC_BITS);
        prod_d  = prod;
        state_d = S_INIT;
      end
      S_INIT: begin
        sy_d    = dgrt_pkg::SIDE_W'(prod_q >> dgrt_pkg::FRAC_BITS);
        steps_d = '0;
        side_d  = dgrt_pkg::SIDE_X;
        if (limit_q == '0) begin
          status_d = dgrt_pkg::STATUS_LIMIT;
          state_d  = S_DONE;
        end else begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        // Advance the axis with the smaller side distance
        steps_d = steps_q + dgrt_pkg::STEP_W'(1);
        if (take_x) begin
          sx_d   = sum_sat;
          side_d = dgrt_pkg::SIDE_X;
          if (!leave) begin
            mx_d = nx_q ? mx_q - dgrt_pkg::COORD_W'(1) : mx_q + dgrt_pkg::COORD_W'(1);
          end
        end else begin
          sy_d   = sum_sat;
          side_d = dgrt_pkg::SIDE_Y;
          if (!leave) begin
            my_d = ny_q ? my_q - dgrt_pkg::COORD_W'(1) : my_q + dgrt_pkg::COORD_W'(1);
          end
        end
        if (leave) begin
          status_d = dgrt_pkg::STATUS_LEFT;
          state_d  = S_DONE;
        end else begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        // Map read of the new cell is back
        if (map_wall) begin
          status_d = dgrt_pkg::STATUS_WALL;
          state_d  = S_DONE;
        end else if (steps_q == limit_q) begin
          status_d = dgrt_pkg::STATUS_LIMIT;
          state_d  = S_DONE;
        end else begin
          state_d = S_STEP;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, limit register and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= dgrt_pkg::STEP_LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    mx_q     <= mx_d;
    my_q     <= my_d;
    fx_q     <= fx_d;
    fy_q     <= fy_d;
    nx_q     <= nx_d;
    ny_q     <= ny_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    prod_q   <= prod_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    steps_q  <= steps_d;
    side_q   <= side_d;
    status_q <= status_d;
    if (out_load) begin
      out_q.hit_x        <= mx_q;
      out_q.hit_y        <= my_q;
      out_q.hit_side     <= side_q;
      out_q.final_side_x <= sx_q;
      out_q.final_side_y <= sy_q;
      out_q.steps_taken  <= steps_q;
      out_q.status       <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // No item is taken while the map is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !map_ready |-> in_stall_o)
    else $error("item taken during map clear");

  // A step lookup never runs past the step limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> (steps_q != '0 && steps_q <= limit_q))
    else $error("step count outside limit");

  // Limit status only with the step count at the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == dgrt_pkg::STATUS_LIMIT) |-> (steps_q == limit_q))
    else $error("limit status with wrong step count");

  // A loaded result has a defined status code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_data_o.status == dgrt_pkg::STATUS_WALL
                  || out_data_o.status == dgrt_pkg::STATUS_LEFT
                  || out_data_o.status == dgrt_pkg::STATUS_LIMIT))
    else $error("bad result status");

endmodule

FILE: test/dda_grid_ray_traversal_tb.sv
`timescale 1ns / 100ps
// Testbench for dda_grid_ray_traversal: a directed table, then three random phases of map
// writes and ray casts, each ray result checked field by field against the table or a DDA predictor.
// Depends on dgrt_pkg and the block's RTL only.
module dda_grid_ray_traversal_tb;
  import dgrt_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 610;
  localparam int MAX_PRINTS     = 100;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_LIMIT} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    in_t               item;
    logic [STEP_W-1:0] limit;
    out_t              want;
  } dir_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [STEP_W-1:0] cfg_data  = '0;

  // Predictor state: wall map indexed {y, x} and the current step limit
  bit                wall_cells [MAP_CELLS];
  logic [STEP_W-1:0] limit_now = STEP_LIMIT_RESET;

  out_t     pending_hits [$];
  dir_row_t dir_rows [$];

  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int hold_requests  = 0;
  int holds_done     = 0;
  int hold_left      = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int idle_cycles    = 0;

  dda_grid_ray_traversal dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Initial side distance from the fractional part of the start position
  function automatic logic [SIDE_W-1:0] start_side(input logic [POS_W-1:0] pos,
                                                   input logic neg,
                                                   input logic [DELTA_W-1:0] delta);
    logic [SPAN_W-1:0] span;
    logic [PROD_W-1:0] prod;
    if (neg) begin
      span = SPAN_W'(pos[FRAC_BITS-1:0]);
    end else begin
      span = (SPAN_W'(1) << FRAC_BITS) - SPAN_W'(pos[FRAC_BITS-1:0]);
    end
    prod = PROD_W'(span) * PROD_W'(delta);
    return SIDE_W'(prod >> FRAC_BITS);
  endfunction

  function automatic logic [SIDE_W-1:0] side_add(input logic [SIDE_W-1:0] side_dist,
                                                 input logic [DELTA_W-1:0] delta);
    logic [SIDE_W:0] sum;
    sum = {1'b0, side_dist} + (SIDE_W+1)'(delta);
    return sum[SIDE_W] ? {SIDE_W{1'b1}} : sum[SIDE_W-1:0];
  endfunction

  // Apply one item to the predictor; returns 1 with the traced ray for a cast
  function automatic bit trace_ray(input in_t item, output out_t res);
    logic [COORD_W-1:0] mx;
    logic [COORD_W-1:0] my;
    logic [SIDE_W-1:0]  sx;
    logic [SIDE_W-1:0]  sy;
    logic [STEP_W-1:0]  steps;
    logic               side;
    logic [1:0]         status;
    bit                 gone;
    res = '0;
    if (item.mode == MODE_WRITE) begin
      wall_cells[{item.cell_y, item.cell_x}] = item.cell_wall;
      return 1'b0;
    end
    mx     = item.pos_x[POS_W-1:FRAC_BITS];
    my     = item.pos_y[POS_W-1:FRAC_BITS];
    sx     = start_side(item.pos_x, item.dir_x_negative, item.delta_x);
    sy     = start_side(item.pos_y, item.dir_y_negative, item.delta_y);
    steps  = '0;
    side   = SIDE_X;
    status = STATUS_LIMIT;
    // Step the axis with the smaller side distance, y on ties
    while (steps < limit_now) begin
      steps++;
      gone = 1'b0;
      if (sx < sy) begin
        sx   = side_add(sx, item.delta_x);
        side = SIDE_X;
        if (item.dir_x_negative) begin
          if (mx == '0) gone = 1'b1;
          else mx--;
        end else begin
          if (mx == COORD_W'(MAP_W - 1)) gone = 1'b1;
          else mx++;
        end
      end else begin
        sy   = side_add(sy, item.delta_y);
        side = SIDE_Y;
        if (item.dir_y_negative) begin
          if (my == '0) gone = 1'b1;
          else my--;
        end else begin
          if (my == COORD_W'(MAP_H - 1)) gone = 1'b1;
          else my++;
        end
      end
      if (gone) begin
        status = STATUS_LEFT;
        break;
      end
      if (wall_cells[{my, mx}]) begin
        status = STATUS_WALL;
        break;
      end
    end
    res.hit_x        = mx;
    res.hit_y        = my;
    res.hit_side     = side;
    res.final_side_x = sx;
    res.final_side_y = sy;
    res.steps_taken  = steps;
    res.status       = status;
    return 1'b1;
  endfunction

  function automatic in_t map_write(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                    input logic wall);
    in_t item;
    item           = '0;
    item.mode      = MODE_WRITE;
    item.cell_x    = x;
    item.cell_y    = y;
    item.cell_wall = wall;
    return item;
  endfunction

  function automatic in_t cast_ray(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                   input logic nx, input logic ny,
                                   input logic [DELTA_W-1:0] dx, input logic [DELTA_W-1:0] dy);
    in_t item;
    item                = '0;
    item.mode           = MODE_CAST;
    item.pos_x          = px;
    item.pos_y          = py;
    item.dir_x_negative = nx;
    item.dir_y_negative = ny;
    item.delta_x        = dx;
    item.delta_y        = dy;
    return item;
  endfunction

  function automatic out_t hit_at(input logic [COORD_W-1:0] hx, input logic [COORD_W-1:0] hy,
                                  input logic side, input logic [SIDE_W-1:0] sx,
                                  input logic [SIDE_W-1:0] sy, input logic [STEP_W-1:0] steps,
                                  input logic [1:0] status);
    out_t res;
    res.hit_x        = hx;
    res.hit_y        = hy;
    res.hit_side     = side;
    res.final_side_x = sx;
    res.final_side_y = sy;
    res.steps_taken  = steps;
    res.status       = status;
    return res;
  endfunction

  // Mostly short deltas, some full range, a few at the extremes
  function automatic logic [DELTA_W-1:0] random_delta();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return DELTA_W'($urandom_range(32'h40000));
    if (pick < 9) return DELTA_W'($urandom);
    return {DELTA_W{1'($urandom_range(1))}};
  endfunction

  task automatic add_row(input row_kind_e kind, input in_t item, input logic [STEP_W-1:0] limit,
                         input out_t want);
    dir_row_t row;
    row.kind  = kind;
    row.item  = item;
    row.limit = limit;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  task automatic flag_mismatch(input string what, input logic [SIDE_W-1:0] got,
                               input logic [SIDE_W-1:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("tb: %s wrong on result %0d: got %0h, expected %0h", what, results_seen, got,
               want);
    end
    mismatches++;
  endtask

  // Offer one item, hold it until the transfer, then record what it should produce
  task automatic send_item(input in_t item, input bit typed, input out_t want);
    out_t traced;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (trace_ray(item, traced)) pending_hits.push_back(typed ? want : traced);
  endtask

  // Drop valid and wait until every ray result is back and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [STEP_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_now = value;
  endtask

  task automatic run_phase(input int n_items, input int drain_at, input int hold_at);
    in_t item;
    for (int i = 0; i < n_items; i++) begin
      if (i == drain_at) wait_idle();
      if (i == hold_at) hold_requests++;
      item.cell_x         = COORD_W'($urandom);
      item.cell_y         = COORD_W'($urandom);
      item.cell_wall      = ($urandom_range(99) < 20);
      item.pos_x          = POS_W'($urandom);
      item.pos_y          = POS_W'($urandom);
      item.dir_x_negative = 1'($urandom);
      item.dir_y_negative = 1'($urandom);
      item.delta_x        = random_delta();
      item.delta_y        = random_delta();
      item.mode           = ($urandom_range(99) < 35) ? MODE_WRITE : MODE_CAST;
      send_item(item, 1'b0, '0);
    end
  endtask

  // Result side: check each transfer, then pick the next stall
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        flag_mismatch("unexpected result", SIDE_W'(out_data.steps_taken), '0);
      end else begin
        want = pending_hits.pop_front();
        if (out_data.hit_x !== want.hit_x)
          flag_mismatch("hit_x", SIDE_W'(out_data.hit_x), SIDE_W'(want.hit_x));
        if (out_data.hit_y !== want.hit_y)
          flag_mismatch("hit_y", SIDE_W'(out_data.hit_y), SIDE_W'(want.hit_y));
        if (out_data.hit_side !== want.hit_side)
          flag_mismatch("hit_side", SIDE_W'(out_data.hit_side), SIDE_W'(want.hit_side));
        if (out_data.final_side_x !== want.final_side_x)
          flag_mismatch("final_side_x", out_data.final_side_x, want.final_side_x);
        if (out_data.final_side_y !== want.final_side_y)
          flag_mismatch("final_side_y", out_data.final_side_y, want.final_side_y);
        if (out_data.steps_taken !== want.steps_taken)
          flag_mismatch("steps_taken", SIDE_W'(out_data.steps_taken), SIDE_W'(want.steps_taken));
        if (out_data.status !== want.status)
          flag_mismatch("status", SIDE_W'(out_data.status), SIDE_W'(want.status));
      end
      results_seen++;
    end
    if (hold_requests != holds_done) begin
      holds_done = hold_requests;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Reset limit 128, empty map: the first two rays leave on the first step
    add_row(ROW_CHECKED, cast_ray('0, '0, 1'b1, 1'b1, '0, '0), '0,
            hit_at(6'd0, 6'd0, SIDE_Y, '0, '0, 12'd1, STATUS_LEFT));
    add_row(ROW_CHECKED, cast_ray('1, '1, 1'b0, 1'b0, '1, '1), '0,
            hit_at(6'd63, 6'd63, SIDE_Y, 40'hFFFF, 40'h1_0000_FFFE, 12'd1, STATUS_LEFT));
    add_row(ROW_ITEM, cast_ray(22'h200000, 22'h208000, 1'b0, 1'b1, 32'h10000, 32'h18000), '0,
            '0);
    add_row(ROW_ITEM, cast_ray('1, '0, 1'b1, 1'b0, '1, '0), '0, '0);
    // No step allowed
    add_row(ROW_LIMIT, '0, STEP_W'(0), '0);
    add_row(ROW_CHECKED, cast_ray(22'h058000, 22'h0A0000, 1'b0, 1'b0, 32'h20000, 32'h10000), '0,
            hit_at(6'd5, 6'd10, SIDE_X, 40'h10000, 40'h10000, 12'd0, STATUS_LIMIT));
    // One step: limit reached, then a wall found on the last allowed step
    add_row(ROW_LIMIT, '0, STEP_W'(1), '0);
    add_row(ROW_CHECKED, cast_ray(22'h0A0000, 22'h0A0000, 1'b0, 1'b0, 32'h10000, 32'h20000), '0,
            hit_at(6'd11, 6'd10, SIDE_X, 40'h20000, 40'h20000, 12'd1, STATUS_LIMIT));
    add_row(ROW_ITEM, map_write(6'd11, 6'd10, 1'b1), '0, '0);
    add_row(ROW_CHECKED, cast_ray(22'h0A0000, 22'h0A0000, 1'b0, 1'b0, 32'h10000, 32'h20000), '0,
            hit_at(6'd11, 6'd10, SIDE_X, 40'h20000, 40'h20000, 12'd1, STATUS_WALL));
    // Start inside a wall cell, and a tie that goes to y
    add_row(ROW_ITEM, cast_ray(22'h0B4000, 22'h0A0000, 1'b1, 1'b0, 32'h10000, 32'h10000), '0,
            '0);
    add_row(ROW_CHECKED, cast_ray(22'h0A0000, 22'h0A0000, 1'b0, 1'b0, 32'h10000, 32'h10000), '0,
            hit_at(6'd10, 6'd11, SIDE_Y, 40'h10000, 40'h20000, 12'd1, STATUS_LIMIT));
    // Highest limit: leave over an x line, then walls in three corners
    add_row(ROW_LIMIT, '0, STEP_W'(4095), '0);
    add_row(ROW_CHECKED, cast_ray(22'h000000, 22'h200000, 1'b1, 1'b0, '0, 32'h10000), '0,
            hit_at(6'd0, 6'd32, SIDE_X, '0, 40'h10000, 12'd1, STATUS_LEFT));
    add_row(ROW_ITEM, map_write(6'd63, 6'd0, 1'b1), '0, '0);
    add_row(ROW_ITEM, map_write(6'd0, 6'd63, 1'b1), '0, '0);
    add_row(ROW_ITEM, map_write(6'd63, 6'd63, 1'b1), '0, '0);
    add_row(ROW_ITEM, cast_ray(22'h008000, 22'h008000, 1'b0, 1'b0, 32'h10000, 32'h10000), '0,
            '0);
    add_row(ROW_ITEM, cast_ray(22'h3E8000, 22'h008000, 1'b0, 1'b1, 32'h10000, 32'h40000), '0,
            '0);
    add_row(ROW_ITEM, cast_ray(22'h008000, 22'h3E8000, 1'b1, 1'b0, 32'h40000, 32'h10000), '0,
            '0);
    add_row(ROW_ITEM, map_write(6'd11, 6'd10, 1'b0), '0, '0);
    add_row(ROW_ITEM, cast_ray(22'h0A0000, 22'h0A0000, 1'b0, 1'b0, 32'h10000, 32'h20000), '0,
            '0);
    add_row(ROW_ITEM, map_write(6'd63, 6'd63, 1'b0), '0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_LIMIT) begin
        write_limit(dir_rows[r].limit);
      end else begin
        send_item(dir_rows[r].item, dir_rows[r].kind == ROW_CHECKED, dir_rows[r].want);
      end
    end

    // Receiver idles more than sender; pause the sender mid-phase until all results are back
    write_limit(STEP_W'(4095));
    tx_idle_pct = 29;
    rx_idle_pct = 48;
    run_phase(PHASE_ITEMS, 300, -1);

    // Sender idles more; short limits end many rays early
    write_limit(STEP_W'($urandom_range(12, 1)));
    tx_idle_pct = 48;
    rx_idle_pct = 29;
    run_phase(PHASE_ITEMS, -1, -1);

    // Full rate, with one long receiver hold-off to back up the input
    write_limit(STEP_W'(200));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(PHASE_ITEMS, -1, 150);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
